[design/tstu_pkg.sv]
// Shared types and constants of the timestamp slot table update block.
package tstu_pkg;

	localparam int SEQ_W = 32;
	localparam int TIME_W = 64;
	localparam int SLOT_W = 7;
	localparam int NOMINAL_LIMIT = 100;
	localparam logic [SEQ_W-1:0] SEQ_MAX = 32'hFFFF_FFFF;

	// Action codes reported with each result
	typedef enum logic [1:0] {
		ACT_UPDATE = 2'd0,
		ACT_REUSE  = 2'd1,
		ACT_APPEND = 2'd2,
		ACT_EVICT  = 2'd3
	} action_t;

	// Engine states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	// Result of one request
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		action_t           action;
	} result_t;

endpackage

[design/tstu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tstu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/tstu_engine.sv]
// Scan sequencer: walks the filled slots once, tracks match, stale and minimum, then writes back.
module tstu_engine
	import tstu_pkg::*;
#(
	parameter int TABLE_DEPTH = 128,
	parameter int FILL_LIMIT = (TABLE_DEPTH < NOMINAL_LIMIT) ? TABLE_DEPTH : NOMINAL_LIMIT,
	parameter int IDX_W = (FILL_LIMIT > 1) ? $clog2(FILL_LIMIT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SEQ_W-1:0]  entry_seq,
	input  logic [SEQ_W-1:0]  current_seq,
	input  logic              out_free,
	output logic              idle,
	output logic              rd_en,
	output logic [IDX_W-1:0]  rd_addr,
	input  logic [SEQ_W-1:0]  rd_data,
	output logic              wr_seq_en,
	output logic              wr_time_en,
	output logic [IDX_W-1:0]  wr_addr,
	output logic              done,
	output result_t           result
);

	localparam int CNT_W = $clog2(FILL_LIMIT + 1);
	localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(FILL_LIMIT);

	state_t           state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             stale_found_q;
	logic [IDX_W-1:0] stale_idx_q;
	logic [SEQ_W-1:0] min_val_q;
	logic [IDX_W-1:0] min_idx_q;
	logic             issue;
	action_t          action;
	logic [IDX_W-1:0] target;

	assign idle = (state_q == ST_IDLE);
	assign issue = (state_q == ST_SCAN) && (cnt_q < fill_q);
	assign rd_en = issue;
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign done = (state_q == ST_WRITE) && out_free;

	// Pick the action from the scan results
	always_comb begin
		if (match_found_q) begin
			action = ACT_UPDATE;
			target = match_idx_q;
		end else if (stale_found_q) begin
			action = ACT_REUSE;
			target = stale_idx_q;
		end else if (fill_q < LIMIT_C) begin
			action = ACT_APPEND;
			target = fill_q[IDX_W-1:0];
		end else begin
			action = ACT_EVICT;
			target = min_idx_q;
		end
	end

	assign wr_time_en = done;
	assign wr_seq_en = done && (action != ACT_UPDATE);
	assign wr_addr = target;
	assign result.action = action;
	assign result.slot = SLOT_W'(target);

	// Sequencer, read pipeline and trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			cnt_q <= '0;
			valid_s1 <= 1'b0;
			addr_s1 <= '0;
			match_found_q <= 1'b0;
			match_idx_q <= '0;
			stale_found_q <= 1'b0;
			stale_idx_q <= '0;
			min_val_q <= SEQ_MAX;
			min_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
						cnt_q <= '0;
						valid_s1 <= 1'b0;
						match_found_q <= 1'b0;
						stale_found_q <= 1'b0;
						min_val_q <= SEQ_MAX;
						min_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					// advance the read address
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					valid_s1 <= issue;
					addr_s1 <= cnt_q[IDX_W-1:0];
					// evaluate the slot read last cycle
					if (valid_s1) begin
						if (!match_found_q && (rd_data == entry_seq)) begin
							match_found_q <= 1'b1;
							match_idx_q <= addr_s1;
						end
						if (!stale_found_q && (rd_data < current_seq)) begin
							stale_found_q <= 1'b1;
							stale_idx_q <= addr_s1;
						end
						if (rd_data < min_val_q) begin
							min_val_q <= rd_data;
							min_idx_q <= addr_s1;
						end
					end
					if (!issue && !valid_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// hold until the output register can take the result
					if (out_free) begin
						state_q <= ST_IDLE;
						if (action == ACT_APPEND) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LIMIT_C)
		else $error("fill count above limit");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CNT_W'(addr_s1) < fill_q))
		else $error("scan read beyond filled slots");

	a_write_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		wr_time_en |=> (state_q == ST_IDLE))
		else $error("engine not idle after write-back");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (action == ACT_APPEND)) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("append did not grow the table");

endmodule

[design/timestamp_slot_table_update.sv]
// Top level of the timestamp slot table update block.
// Each request carries one timestamp entry and the stream's current sequence number; the block
// looks for a slot with the same sequence number, else the first stale slot, else appends, else
// evicts the lowest-index slot holding the smallest sequence number, and returns one result with
// the action taken and the slot written. The single read port of the sequence-number RAM is walked
// once over the filled slots, of which there are at most min(TABLE_DEPTH, 100); then the result
// is written back once the output register can take it. A new request is taken once the write-back
// is done, even while the previous result still waits in the output register.
// No clearing pass is needed after reset.
module timestamp_slot_table_update
	import tstu_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // entry_seq[31:0], entry_time[95:32], current_seq[127:96]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata   // action[1:0], slot[8:2], zero fill[15:9]
);

	localparam int FILL_LIMIT = (TABLE_DEPTH < NOMINAL_LIMIT) ? TABLE_DEPTH : NOMINAL_LIMIT;
	localparam int IDX_W = (FILL_LIMIT > 1) ? $clog2(FILL_LIMIT) : 1;

	logic [SEQ_W-1:0]  entry_seq_q;
	logic [TIME_W-1:0] entry_time_q;
	logic [SEQ_W-1:0]  current_seq_q;
	logic              m_tvalid_q;
	result_t           result_q;
	logic              accept;
	logic              out_free;
	logic              idle;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [SEQ_W-1:0]  rd_data;
	logic              wr_seq_en;
	logic              wr_time_en;
	logic [IDX_W-1:0]  wr_addr;
	logic              done;
	result_t           result;

	assign s_tready = idle;
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {7'd0, result_q.slot, result_q.action};

	// Capture the request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_seq_q <= s_tdata[31:0];
			entry_time_q <= s_tdata[95:32];
			current_seq_q <= s_tdata[127:96];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			result_q <= result;
		end
	end

	tstu_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.entry_seq  (entry_seq_q),
		.current_seq(current_seq_q),
		.out_free   (out_free),
		.idle       (idle),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_seq_en  (wr_seq_en),
		.wr_time_en (wr_time_en),
		.wr_addr    (wr_addr),
		.done       (done),
		.result     (result)
	);

	// Sequence numbers of the slots
	tstu_ram #(
		.WIDTH(SEQ_W),
		.DEPTH(FILL_LIMIT),
		.ADDR_W(IDX_W)
	) u_seq_ram (
		.clk    (clk),
		.wr_en  (wr_seq_en),
		.wr_addr(wr_addr),
		.wr_data(entry_seq_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Presentation times of the slots
	tstu_ram #(
		.WIDTH(TIME_W),
		.DEPTH(FILL_LIMIT),
		.ADDR_W(IDX_W)
	) u_time_ram (
		.clk    (clk),
		.wr_en  (wr_time_en),
		.wr_addr(wr_addr),
		.wr_data(entry_time_q),
		.rd_en  (1'b0),
		.rd_addr({IDX_W{1'b0}}),
		.rd_data()
	);

endmodule
